@@ src/dhrp_pkg.sv @@
// Shared types and constants for the DHCP reply parser.
// Holds the packet layout offsets, option codes, status codes and the option walker state.
// No dependencies.
package dhrp_pkg;

    localparam int MAX_PACKET_BYTES = 1024;
    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);

    localparam int STATION_W = 48;
    localparam int XID_W = 32;
    localparam int MSG_TYPE_W = 8;
    localparam int CFG_DATA_W = 48;
    localparam int CFG_INDEX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_STATION  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_XID      = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MSG_TYPE = 2'd2;

    // Header layout offsets.
    localparam logic [POS_W-1:0] POS_OPCODE       = POS_W'(0);
    localparam logic [POS_W-1:0] POS_XID_FIRST    = POS_W'(4);
    localparam logic [POS_W-1:0] POS_XID_LAST     = POS_W'(7);
    localparam logic [POS_W-1:0] POS_YIADDR_FIRST = POS_W'(16);
    localparam logic [POS_W-1:0] POS_YIADDR_LAST  = POS_W'(19);
    localparam logic [POS_W-1:0] POS_CHADDR_FIRST = POS_W'(28);
    localparam logic [POS_W-1:0] POS_CHADDR_LAST  = POS_W'(33);
    localparam logic [POS_W-1:0] POS_OPTIONS      = POS_W'(240);
    localparam logic [POS_W-1:0] POS_LIMIT        = POS_W'(MAX_PACKET_BYTES);

    localparam logic [7:0] OP_BOOTREPLY = 8'd2;

    // Option codes.
    localparam logic [7:0] OPT_PAD       = 8'd0;
    localparam logic [7:0] OPT_ROUTER    = 8'd3;
    localparam logic [7:0] OPT_MSG_TYPE  = 8'd53;
    localparam logic [7:0] OPT_SERVER_ID = 8'd54;
    localparam logic [7:0] OPT_END       = 8'd255;

    localparam logic [2:0] ADDR_BYTES = 3'd4;

    // Header error flag bits.
    localparam int HDR_ADDR = 0;
    localparam int HDR_OP   = 1;
    localparam int HDR_XID  = 2;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_TOO_SHORT = 3'd1,
        ST_ADDR      = 3'd2,
        ST_NOT_REPLY = 3'd3,
        ST_XID       = 3'd4,
        ST_TYPE      = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PH_CODE  = 2'd0,
        PH_LEN   = 2'd1,
        PH_VALUE = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase      phase;
        logic [7:0]  code;
        logic [7:0]  left;
        logic [31:0] shift;
        logic [2:0]  count;
        logic [31:0] server;
        logic [31:0] gateway;
        logic        server_found;
        logic        gateway_found;
        logic        done;
        logic        type_err;
    } t_walk_state;

endpackage

@@ src/dhrp_walk.sv @@
// Option walker next-state logic for the DHCP reply parser.
// Steps the code/length/value walk by one byte; depends on dhrp_pkg.
module dhrp_walk (
    input  logic                    i_enable,
    input  logic [7:0]              i_byte,
    input  logic [7:0]              i_exp_type,
    input  dhrp_pkg::t_walk_state   i_state,
    output dhrp_pkg::t_walk_state   o_state
);
    import dhrp_pkg::*;

    t_walk_state n_st;
    logic        n_finish;
    logic [1:0]  n_first_sel;
    logic [7:0]  n_first;

    always_comb begin
        n_st = i_state;
        n_finish = 1'b0;
        if (i_enable && !i_state.done) begin
            case (i_state.phase)
                PH_CODE: begin
                    if (i_byte == OPT_END) begin
                        n_st.done = 1'b1;
                    end else if (i_byte != OPT_PAD) begin
                        n_st.code = i_byte;
                        n_st.phase = PH_LEN;
                    end
                end
                PH_LEN: begin
                    n_st.left = i_byte;
                    n_st.count = 3'd0;
                    n_st.shift = '0;
                    if (i_byte == 8'd0) begin
                        n_finish = 1'b1;
                    end else begin
                        n_st.phase = PH_VALUE;
                    end
                end
                PH_VALUE: begin
                    // Only the first four value bytes are kept.
                    if (i_state.count < ADDR_BYTES) begin
                        n_st.shift = {i_state.shift[23:0], i_byte};
                        n_st.count = i_state.count + 3'd1;
                    end
                    n_st.left = i_state.left - 8'd1;
                    if (n_st.left == 8'd0) begin
                        n_finish = 1'b1;
                    end
                end
                default: begin
                    n_st.phase = PH_CODE;
                end
            endcase
        end

        // The first value byte sits count-1 bytes up from the bottom.
        n_first_sel = 2'(n_st.count - 3'd1);
        n_first = n_st.shift[{n_first_sel, 3'b000} +: 8];

        if (n_finish) begin
            n_st.phase = PH_CODE;
            if (n_st.code == OPT_ROUTER && n_st.count == ADDR_BYTES) begin
                n_st.gateway = n_st.shift;
                n_st.gateway_found = 1'b1;
            end else if (n_st.code == OPT_SERVER_ID && n_st.count == ADDR_BYTES) begin
                n_st.server = n_st.shift;
                n_st.server_found = 1'b1;
            end else if (n_st.code == OPT_MSG_TYPE && n_st.count != 3'd0) begin
                if (n_first != i_exp_type) begin
                    n_st.type_err = 1'b1;
                    n_st.done = 1'b1;
                end
            end
        end
    end

    assign o_state = n_st;

endmodule

@@ src/dhcp_reply_parser.sv @@
// Top level of the DHCP reply parser: input register, header checks and result register.
// Depends on dhrp_pkg and dhrp_walk.
//
// The parser takes one byte of a received DHCP/BOOTP reply per request and can accept a
// new byte every cycle unless the input is stalled; each byte passes through one input
// register and the combinational header and option logic, and the result of the last
// byte is registered. Exactly one result is given per packet, for the byte that has
// the last-byte mark set. Bytes beyond the packet limit are ignored, though the mark still
// ends the packet. The input stalls only when a result is waiting and the downstream side
// stalls it. Configuration must be written while no packet is in progress.
module dhcp_reply_parser (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [dhrp_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [dhrp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [7:0]                            i_data_byte,
    input  logic                                  i_last_byte,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output dhrp_pkg::t_status                     o_status,
    output logic [31:0]                           o_assigned_address,
    output logic [31:0]                           o_server_address,
    output logic                                  o_server_valid,
    output logic [31:0]                           o_gateway_address,
    output logic                                  o_gateway_valid
);
    import dhrp_pkg::*;

    logic [STATION_W-1:0]  r_station;
    logic [XID_W-1:0]      r_xid;
    logic [MSG_TYPE_W-1:0] r_exp_type;

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [2:0]       r_hdr;
    logic [2:0]       n_hdr;
    logic [31:0]      r_offer;
    logic [31:0]      n_offer;
    t_walk_state      r_walk;
    t_walk_state      n_walk;
    t_walk_state      n_walk_clr;

    logic       w_fire;
    logic       w_step;
    logic       w_walk_en;
    logic       w_out_take;
    logic [1:0] w_xid_sel;
    logic [2:0] w_sta_sel;
    t_status    n_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_station  <= '0;
            r_xid      <= XID_W'(1);
            r_exp_type <= MSG_TYPE_W'(2);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_STATION:  r_station  <= i_cfg_data;
                CFG_XID:      r_xid      <= i_cfg_data[XID_W-1:0];
                CFG_MSG_TYPE: r_exp_type <= i_cfg_data[MSG_TYPE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A byte without the mark never produces a result, so it can always move on.
    assign w_out_take = o_out_valid && !i_out_stall;
    assign w_fire = r_in_valid && (!r_in_last || !o_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !w_fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
    end

    assign w_step = r_pos < POS_LIMIT;
    assign w_walk_en = w_step && (r_pos >= POS_OPTIONS);
    assign w_xid_sel = 2'(POS_XID_LAST - r_pos);
    assign w_sta_sel = 3'(POS_CHADDR_LAST - r_pos);

    always_comb begin
        n_pos = r_pos;
        n_hdr = r_hdr;
        n_offer = r_offer;
        if (w_step) begin
            n_pos = r_pos + POS_W'(1);
            if (r_pos == POS_OPCODE && r_in_byte != OP_BOOTREPLY) begin
                n_hdr[HDR_OP] = 1'b1;
            end
            if (r_pos >= POS_XID_FIRST && r_pos <= POS_XID_LAST
                    && r_in_byte != r_xid[{w_xid_sel, 3'b000} +: 8]) begin
                n_hdr[HDR_XID] = 1'b1;
            end
            if (r_pos >= POS_YIADDR_FIRST && r_pos <= POS_YIADDR_LAST) begin
                n_offer = {r_offer[23:0], r_in_byte};
            end
            if (r_pos >= POS_CHADDR_FIRST && r_pos <= POS_CHADDR_LAST
                    && r_in_byte != r_station[{w_sta_sel, 3'b000} +: 8]) begin
                n_hdr[HDR_ADDR] = 1'b1;
            end
        end
    end

    dhrp_walk u_walk (
        .i_enable   (w_walk_en),
        .i_byte     (r_in_byte),
        .i_exp_type (r_exp_type),
        .i_state    (r_walk),
        .o_state    (n_walk)
    );

    // Per-packet walk state returns to its start; the committed addresses are kept.
    always_comb begin
        n_walk_clr = '0;
        n_walk_clr.phase = PH_CODE;
        n_walk_clr.server = n_walk.server;
        n_walk_clr.gateway = n_walk.gateway;
    end

    always_comb begin
        if (n_pos < POS_OPTIONS) begin
            n_status = ST_TOO_SHORT;
        end else if (n_hdr[HDR_ADDR]) begin
            n_status = ST_ADDR;
        end else if (n_hdr[HDR_OP]) begin
            n_status = ST_NOT_REPLY;
        end else if (n_hdr[HDR_XID]) begin
            n_status = ST_XID;
        end else if (n_walk.type_err) begin
            n_status = ST_TYPE;
        end else begin
            n_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hdr   <= '0;
            r_offer <= '0;
            r_walk  <= '0;
        end else if (w_fire) begin
            if (r_in_last) begin
                r_pos   <= '0;
                r_hdr   <= '0;
                r_offer <= '0;
                r_walk  <= n_walk_clr;
            end else begin
                r_pos   <= n_pos;
                r_hdr   <= n_hdr;
                r_offer <= n_offer;
                r_walk  <= n_walk;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (w_fire && r_in_last) begin
            o_out_valid <= 1'b1;
        end else if (w_out_take) begin
            o_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && r_in_last) begin
            o_status <= n_status;
            if (n_status == ST_OK) begin
                o_assigned_address <= n_offer;
                o_server_address   <= n_walk.server;
                o_server_valid     <= n_walk.server_found;
                o_gateway_address  <= n_walk.gateway;
                o_gateway_valid    <= n_walk.gateway_found;
            end else begin
                o_assigned_address <= '0;
                o_server_address   <= '0;
                o_server_valid     <= 1'b0;
                o_gateway_address  <= '0;
                o_gateway_valid    <= 1'b0;
            end
        end
    end

    a_pos_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_LIMIT)
        else $error("byte position ran past the packet limit");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && r_in_last) |=> (r_pos == '0 && r_hdr == '0 && !r_walk.done))
        else $error("packet state not cleared after the last byte");

    a_error_zeroes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |->
            (o_assigned_address == '0 && !o_server_valid && !o_gateway_valid))
        else $error("error result carries address data");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_walk.count <= ADDR_BYTES)
        else $error("option value count exceeded four bytes");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_last && o_out_valid && i_out_stall) |=> r_in_valid)
        else $error("last byte dropped while the result was stalled");

endmodule
